>>> rtl/core/pfrr_pkg.sv
// Shared types and constants for the parameter frame receiver and responder.
`timescale 1ns / 1ps

package pfrr_pkg;

  // Frame bytes
  localparam logic [7:0] HDR        = 8'hAA;
  localparam logic [7:0] ADDR_OUT   = 8'hFF;
  localparam logic [7:0] FN_READ    = 8'hE1;
  localparam logic [7:0] FN_WRITE   = 8'hE2;
  localparam logic [7:0] FN_ACK     = 8'h00;
  localparam logic [7:0] LEN_READ   = 8'd6;
  localparam logic [7:0] LEN_ACK    = 8'd3;

  // Receive buffer and reply layout
  localparam int         KEPT_BYTES = 6;
  localparam int         BODY_SLOTS = 10;
  localparam logic [3:0] BODY_READ  = 4'd10;
  localparam logic [3:0] BODY_ACK   = 4'd7;

  // Table entry that comes out of reset with a nonzero value
  localparam int          DEFAULT_ID  = 12;
  localparam logic [31:0] DEFAULT_VAL = 32'd123;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_FUNC,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_ACC
  } pfrr_phase_t;

  // Request from the parser for one good frame
  typedef struct packed {
    logic        valid;
    logic        is_read;
    logic [15:0] id;
    logic [31:0] wval;
    logic [7:0]  rsum;
    logic [7:0]  racc;
  } pfrr_req_t;

  // Reply job handed to the transmitter
  typedef struct packed {
    logic        valid;
    logic        is_read;
    logic [15:0] id;
    logic [31:0] value;
    logic [7:0]  rsum;
    logic [7:0]  racc;
  } pfrr_job_t;

endpackage

>>> rtl/core/pfrr_if.sv
// Stream interfaces for received bytes and reply bytes.
`timescale 1ns / 1ps

interface pfrr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfrr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

>>> rtl/core/pfrr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pfrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 13
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pfrr_parse.sv
// Frame parser: header hunt, running checksums, receive buffer, frame check.
`timescale 1ns / 1ps

module pfrr_parse #(
  parameter int MAX_PAYLOAD = 50
) (
  input  logic              clk,
  input  logic              rst,
  pfrr_rx_if.sink           rx,
  input  logic              hold,
  output pfrr_pkg::pfrr_req_t req
);
  import pfrr_pkg::*;

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int PC_W  = $clog2(MAX_PAYLOAD + 3);

  pfrr_phase_t      phase, phase_next;
  logic [7:0]       func;
  logic [LEN_W-1:0] len;
  logic [PC_W-1:0]  pcount;
  logic [7:0]       sum, acc, rx_sum;
  logic [7:0]       kept [KEPT_BYTES];
  logic [7:0]       kept_upd [KEPT_BYTES];

  logic       beat, oversize, data_done, check_ok, fn_known;
  logic       start, add_en, keep_en, take_func, take_len, take_rxsum, frame_end;
  logic [7:0] b, sum_add, acc_add;

  assign b         = rx.rx_byte;
  assign beat      = rx.valid && rx.ready;
  assign oversize  = {1'b0, b} > 9'(MAX_PAYLOAD);
  assign data_done = ((PC_W+1)'(pcount) + (PC_W+1)'(1)) >= (PC_W+1)'(len);
  assign sum_add   = sum + b;
  assign acc_add   = acc + sum_add;
  assign check_ok  = (rx_sum == sum) && (b == acc);
  assign fn_known  = (func == FN_READ) || (func == FN_WRITE);

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT: if (beat && b == HDR) phase_next = PH_ADDR;
      PH_ADDR: if (beat) phase_next = PH_FUNC;
      PH_FUNC: if (beat) phase_next = PH_LEN;
      PH_LEN: begin
        if (beat) begin
          if (oversize) phase_next = PH_HUNT;
          else if (b == 8'd0) phase_next = PH_SUM;
          else phase_next = PH_DATA;
        end
      end
      PH_DATA: if (beat && data_done) phase_next = PH_SUM;
      PH_SUM:  if (beat) phase_next = PH_ACC;
      PH_ACC:  if (beat) phase_next = PH_HUNT;
      default: phase_next = PH_HUNT;
    endcase
  end

  // Per-phase controls
  always_comb begin
    start      = 1'b0;
    add_en     = 1'b0;
    keep_en    = 1'b0;
    take_func  = 1'b0;
    take_len   = 1'b0;
    take_rxsum = 1'b0;
    frame_end  = 1'b0;
    rx.ready   = 1'b1;
    unique case (phase)
      PH_HUNT: start = (b == HDR);
      PH_ADDR: add_en = 1'b1;
      PH_FUNC: begin
        add_en    = 1'b1;
        take_func = 1'b1;
      end
      PH_LEN: begin
        add_en   = !oversize;
        take_len = !oversize;
      end
      PH_DATA: begin
        add_en  = 1'b1;
        keep_en = 1'b1;
      end
      PH_SUM: begin
        keep_en    = 1'b1;
        take_rxsum = 1'b1;
      end
      PH_ACC: begin
        keep_en   = 1'b1;
        frame_end = 1'b1;
        // stall the closing byte while the previous reply job still waits
        rx.ready  = !hold;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < KEPT_BYTES; i++) begin
      kept_upd[i] = (keep_en && pcount == PC_W'(i)) ? b : kept[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HUNT;
      func   <= '0;
      len    <= '0;
      pcount <= '0;
      sum    <= '0;
      acc    <= '0;
      rx_sum <= '0;
      for (int i = 0; i < KEPT_BYTES; i++) kept[i] <= '0;
    end else begin
      phase <= phase_next;
      if (beat) begin
        if (start) begin
          sum    <= HDR;
          acc    <= HDR;
          pcount <= '0;
          len    <= '0;
        end
        if (add_en) begin
          sum <= sum_add;
          acc <= acc_add;
        end
        if (take_func) func <= b;
        if (take_len) len <= LEN_W'(b);
        if (take_rxsum) rx_sum <= b;
        if (keep_en) begin
          pcount <= pcount + PC_W'(1);
          kept   <= kept_upd;
        end
      end
    end
  end

  assign req.valid   = beat && frame_end && check_ok && fn_known;
  assign req.is_read = (func == FN_READ);
  assign req.id      = {kept_upd[1], kept_upd[0]};
  assign req.wval    = {kept_upd[5], kept_upd[4], kept_upd[3], kept_upd[2]};
  assign req.rsum    = rx_sum;
  assign req.racc    = b;

endmodule

>>> rtl/core/pfrr_table.sv
// Parameter table: RAM with valid bits, read/write issue and one pending reply job.
`timescale 1ns / 1ps

module pfrr_table #(
  parameter int TABLE_ENTRIES = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  pfrr_pkg::pfrr_req_t req,
  input  logic                take,
  output pfrr_pkg::pfrr_job_t job
);
  import pfrr_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic             in_range, we, re;
  logic [IDX_W-1:0] idx;
  logic [31:0]      rdata;
  logic             vld [TABLE_ENTRIES];

  logic             pend_valid, pend_read, pend_hit, pend_vld;
  logic [IDX_W-1:0] pend_idx;
  logic [15:0]      pend_id;
  logic [7:0]       pend_rsum, pend_racc;
  logic             pend_default;

  assign in_range = req.id < 16'(TABLE_ENTRIES);
  assign idx      = req.id[IDX_W-1:0];
  assign we       = req.valid && !req.is_read && in_range;
  assign re       = req.valid && req.is_read && in_range;

  pfrr_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (req.wval),
    .re    (re),
    .raddr (idx),
    .rdata (rdata)
  );

  // valid bits: an entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) vld[i] <= 1'b0;
    end else if (we) begin
      vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req.valid) begin
      pend_valid <= 1'b1;
    end else if (take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      pend_read <= req.is_read;
      pend_hit  <= in_range;
      pend_vld  <= vld[idx];
      pend_idx  <= idx;
      pend_id   <= req.id;
      pend_rsum <= req.rsum;
      pend_racc <= req.racc;
    end
  end

  assign pend_default = (DEFAULT_ID < TABLE_ENTRIES) && (16'(pend_idx) == 16'(DEFAULT_ID));

  always_comb begin
    job.valid   = pend_valid;
    job.is_read = pend_read;
    job.id      = pend_id;
    job.rsum    = pend_rsum;
    job.racc    = pend_racc;
    if (!pend_hit) job.value = '0;
    else if (pend_vld) job.value = rdata;
    else if (pend_default) job.value = DEFAULT_VAL;
    else job.value = '0;
  end

endmodule

>>> rtl/core/pfrr_reply.sv
// Reply transmitter: serializes one reply frame and appends its checksums.
`timescale 1ns / 1ps

module pfrr_reply (
  input  logic                clk,
  input  logic                rst,
  input  pfrr_pkg::pfrr_job_t job,
  output logic                take,
  pfrr_tx_if.source           tx
);
  import pfrr_pkg::*;

  logic       busy, beat, last;
  logic [3:0] cnt, len;
  logic [7:0] sum, acc, cur;
  logic [7:0] body [BODY_SLOTS];

  always_comb begin
    if (cnt == len) cur = sum;
    else if (cnt == len + 4'd1) cur = acc;
    else cur = body[cnt];
  end

  assign last       = (cnt == len + 4'd1);
  assign tx.valid   = busy;
  assign tx.tx_byte = cur;
  assign tx.tx_last = last;
  assign beat       = tx.valid && tx.ready;
  assign take       = job.valid && (!busy || (beat && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      len  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
      len  <= job.is_read ? BODY_READ : BODY_ACK;
    end else if (beat) begin
      if (last) busy <= 1'b0;
      else cnt <= cnt + 4'd1;
    end
  end

  // checksums accumulate over the body bytes only
  always_ff @(posedge clk) begin
    if (take) begin
      sum <= '0;
      acc <= '0;
    end else if (beat && cnt < len) begin
      sum <= sum + cur;
      acc <= acc + sum + cur;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      body[0] <= HDR;
      body[1] <= ADDR_OUT;
      if (job.is_read) begin
        body[2] <= FN_WRITE;
        body[3] <= LEN_READ;
        body[4] <= job.id[7:0];
        body[5] <= job.id[15:8];
        body[6] <= job.value[7:0];
        body[7] <= job.value[15:8];
        body[8] <= job.value[23:16];
        body[9] <= job.value[31:24];
      end else begin
        body[2] <= FN_ACK;
        body[3] <= LEN_ACK;
        body[4] <= FN_WRITE;
        body[5] <= job.rsum;
        body[6] <= job.racc;
        body[7] <= '0;
        body[8] <= '0;
        body[9] <= '0;
      end
    end
  end

endmodule

>>> rtl/core/param_frame_receiver_responder.sv
// Top level of the parameter frame receiver and responder.
`timescale 1ns / 1ps
//
//  Channel | Dir | Payload          | Beat meaning
//  --------+-----+------------------+-------------------------------------------
//  rx      | in  | rx_byte[7:0]     | one received serial byte
//  tx      | out | tx_byte, tx_last | one reply byte; tx_last on the acc byte
//
//  Received bytes are taken one per cycle. The closing acc byte of a frame is
//  held off only while the previous reply job still waits for the transmitter,
//  so the input stalls only when replies back up behind a busy tx channel.
//  A reply leaves one byte per cycle while tx is ready: 12 bytes for a read
//  reply, 9 for an ack. When the transmitter is free, the job and the table
//  read are registered first, and the transmitter then loads the frame and
//  offers its first beat. The table is a RAM with registered read data;
//  per-entry valid bits give the reset contents (zero, entry 12 = 123), so no
//  clearing pass runs after reset. Reset (rst, synchronous) returns the
//  parser to the header hunt and drops any queued reply.

module param_frame_receiver_responder #(
  parameter int MAX_PAYLOAD   = 50,
  parameter int TABLE_ENTRIES = 13
) (
  input logic       clk,
  input logic       rst,
  pfrr_rx_if.sink   rx,
  pfrr_tx_if.source tx
);
  import pfrr_pkg::*;

  pfrr_req_t req;
  pfrr_job_t job;
  logic      take;

  // Parse frames, check the sum and acc bytes, raise one request per good frame
  pfrr_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .hold (job.valid),
    .req  (req)
  );

  // Read or write the table entry and hold the resulting reply job
  pfrr_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .take (take),
    .job  (job)
  );

  // Send the reply frame beat by beat
  pfrr_reply u_reply (
    .clk  (clk),
    .rst  (rst),
    .job  (job),
    .take (take),
    .tx   (tx)
  );

endmodule
